/* design/rmh_pkg.sv */
// Shared types and constants for the two-heap running median block.
package rmh_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CHILD_W    = IDX_W + 2;
   localparam int SAMPLE_W   = 32;
   localparam int MED_W      = 33;
   localparam int COUNT_W    = 12;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // command into one heap, valid for one cycle while the heap is idle
   typedef struct packed {
      logic       push;
      logic       repl;
      sample_type val;
   } heap_cmd_type;

   // status out of one heap
   typedef struct packed {
      logic             busy;
      sample_type       top;
      logic [CNT_W-1:0] cnt;
   } heap_stat_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_UP_RD,
      H_UP_CMP,
      H_DN_RDL,
      H_DN_RDR,
      H_DN_CMP
   } heap_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_RUN,
      T_DONE
   } ctl_state_type;

endpackage

/* design/running_median_two_heaps.sv */
// Running median over two heaps: max-heap for the lower half, min-heap for the upper.
// The longest path is a replaced top that sifts down to a leaf, three memory accesses
// per level (left child, right child, write); a dropped sample skips the heaps.
// One word at a time.
// A word is taken again once the result has moved into the output register.
// Synchronous reset empties both heaps; heap memories are not cleared.
module running_median_two_heaps (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [rmh_pkg::SAMPLE_W-1:0] req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [rmh_pkg::MED_W-1:0] rsp_median_doubled,
   output logic                             rsp_overflow,
   output logic [rmh_pkg::COUNT_W-1:0]      rsp_count
);

   rmh_pkg::ctl_state_type st_ff, st_in;
   rmh_pkg::heap_cmd_type  lo_cmd, up_cmd;
   rmh_pkg::heap_stat_type lo, up;

   logic ovf_ff, ovf_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [rmh_pkg::MED_W-1:0] med_ff, med_in;
   logic [rmh_pkg::COUNT_W-1:0]      cnt_ff, cnt_in;

   logic accept, full, odd, out_free, load;
   logic signed [rmh_pkg::MED_W-1:0] lo_ext, up_ext, med_calc;

   rmh_heap u_lower (.clock(clock), .reset(reset), .is_max(1'b1), .cmd(lo_cmd), .stat(lo));
   rmh_heap u_upper (.clock(clock), .reset(reset), .is_max(1'b0), .cmd(up_cmd), .stat(up));

   assign accept   = req_valid && !req_stall;
   assign full     = (lo.cnt == rmh_pkg::CNT_W'(rmh_pkg::HEAP_DEPTH)) &&
                     (up.cnt == rmh_pkg::CNT_W'(rmh_pkg::HEAP_DEPTH));
   assign odd      = lo.cnt > up.cnt;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (st_ff == rmh_pkg::T_DONE) && out_free;

   // insert decision: at most one replace-top and one push, run side by side
   always_comb begin
      lo_cmd = '{push: 1'b0, repl: 1'b0, val: req_sample};
      up_cmd = '{push: 1'b0, repl: 1'b0, val: req_sample};
      if (accept && !full) begin
         if (odd) begin
            if (req_sample >= lo.top) begin
               up_cmd.push = 1'b1;
            end else begin
               lo_cmd.repl = 1'b1;
               up_cmd.push = 1'b1;
               up_cmd.val  = lo.top;
            end
         end else begin
            if (up.cnt == '0 || req_sample <= up.top) begin
               lo_cmd.push = 1'b1;
            end else begin
               up_cmd.repl = 1'b1;
               lo_cmd.push = 1'b1;
               lo_cmd.val  = up.top;
            end
         end
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         rmh_pkg::T_IDLE: if (accept) st_in = full ? rmh_pkg::T_DONE : rmh_pkg::T_RUN;
         rmh_pkg::T_RUN:  if (!lo.busy && !up.busy) st_in = rmh_pkg::T_DONE;
         rmh_pkg::T_DONE: if (out_free) st_in = rmh_pkg::T_IDLE;
         default:         st_in = rmh_pkg::T_IDLE;
      endcase
   end

   // doubled median from the two tops
   always_comb begin
      lo_ext = rmh_pkg::MED_W'(lo.top);
      up_ext = rmh_pkg::MED_W'(up.top);
      if (lo.cnt == '0)                     med_calc = '0;
      else if (odd || up.cnt == '0)         med_calc = lo_ext + lo_ext;
      else                                  med_calc = lo_ext + up_ext;
   end

   // outputs and result register
   always_comb begin
      req_stall    = (st_ff != rmh_pkg::T_IDLE);
      ovf_in       = accept ? full : ovf_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      med_in       = load ? med_calc : med_ff;
      cnt_in       = load ? rmh_pkg::COUNT_W'({1'b0, lo.cnt} + {1'b0, up.cnt}) : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= rmh_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ovf_ff <= ovf_in;
      med_ff <= med_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = med_ff;
   assign rsp_count          = cnt_ff;

   // overflow word travels with its result
   logic rovf_ff;
   always_ff @(posedge clock) begin
      if (load) rovf_ff <= ovf_ff;
   end
   assign rsp_overflow = rovf_ff;

endmodule

/* design/rmh_heap.sv */
// One binary heap held in a synchronous memory, with push and replace-top sifting.
module rmh_heap (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  is_max,
   input  rmh_pkg::heap_cmd_type cmd,
   output rmh_pkg::heap_stat_type stat
);

   rmh_pkg::heap_state_type state_ff, state_in;
   logic [rmh_pkg::IDX_W-1:0] idx_ff, idx_in;
   rmh_pkg::sample_type       val_ff, val_in;
   rmh_pkg::sample_type       lval_ff, lval_in;
   rmh_pkg::sample_type       top_ff, top_in;
   logic [rmh_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   rmh_pkg::sample_type       rd_ff;

   rmh_pkg::sample_type mem [rmh_pkg::HEAP_DEPTH];

   logic                        we;
   logic [rmh_pkg::IDX_W-1:0]   wa, ra;
   rmh_pkg::sample_type         wd;

   logic [rmh_pkg::IDX_W-1:0]   parent;
   logic [rmh_pkg::CHILD_W-1:0] lchild, rchild, n_wide;
   logic                        has_l, has_r;
   logic                        up_win, l_win, r_win;
   rmh_pkg::sample_type         best_v;

   // index arithmetic and compares
   always_comb begin
      parent = (idx_ff - rmh_pkg::IDX_W'(1)) >> 1;
      lchild = {1'b0, idx_ff, 1'b1};
      rchild = lchild + rmh_pkg::CHILD_W'(1);
      n_wide = rmh_pkg::CHILD_W'(cnt_ff);
      has_l  = lchild < n_wide;
      has_r  = rchild < n_wide;
      up_win = is_max ? (val_ff > rd_ff) : (val_ff < rd_ff);
      l_win  = is_max ? (lval_ff > val_ff) : (lval_ff < val_ff);
      best_v = l_win ? lval_ff : val_ff;
      r_win  = has_r && (is_max ? (rd_ff > best_v) : (rd_ff < best_v));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmh_pkg::H_IDLE: begin
            if (cmd.push)      state_in = rmh_pkg::H_UP_RD;
            else if (cmd.repl) state_in = rmh_pkg::H_DN_RDL;
         end
         rmh_pkg::H_UP_RD: begin
            state_in = (idx_ff == '0) ? rmh_pkg::H_IDLE : rmh_pkg::H_UP_CMP;
         end
         rmh_pkg::H_UP_CMP: begin
            state_in = up_win ? rmh_pkg::H_UP_RD : rmh_pkg::H_IDLE;
         end
         rmh_pkg::H_DN_RDL: begin
            state_in = has_l ? rmh_pkg::H_DN_RDR : rmh_pkg::H_IDLE;
         end
         rmh_pkg::H_DN_RDR: begin
            state_in = rmh_pkg::H_DN_CMP;
         end
         rmh_pkg::H_DN_CMP: begin
            state_in = (l_win || r_win) ? rmh_pkg::H_DN_RDL : rmh_pkg::H_IDLE;
         end
         default: state_in = rmh_pkg::H_IDLE;
      endcase
   end

   // memory accesses and datapath
   always_comb begin
      we      = 1'b0;
      wa      = idx_ff;
      wd      = val_ff;
      ra      = parent;
      idx_in  = idx_ff;
      val_in  = val_ff;
      lval_in = lval_ff;
      cnt_in  = cnt_ff;
      unique case (state_ff)
         rmh_pkg::H_IDLE: begin
            if (cmd.push) begin
               val_in = cmd.val;
               idx_in = cnt_ff[rmh_pkg::IDX_W-1:0];
               cnt_in = cnt_ff + rmh_pkg::CNT_W'(1);
            end else if (cmd.repl) begin
               val_in = cmd.val;
               idx_in = '0;
            end
         end
         rmh_pkg::H_UP_RD: begin
            // root reached: drop the value in place
            we = (idx_ff == '0);
         end
         rmh_pkg::H_UP_CMP: begin
            we = 1'b1;
            if (up_win) begin
               wd     = rd_ff;
               idx_in = parent;
            end
         end
         rmh_pkg::H_DN_RDL: begin
            ra = lchild[rmh_pkg::IDX_W-1:0];
            we = !has_l;
         end
         rmh_pkg::H_DN_RDR: begin
            ra      = rchild[rmh_pkg::IDX_W-1:0];
            lval_in = rd_ff;
         end
         rmh_pkg::H_DN_CMP: begin
            we = 1'b1;
            if (r_win) begin
               wd     = rd_ff;
               idx_in = rchild[rmh_pkg::IDX_W-1:0];
            end else if (l_win) begin
               wd     = lval_ff;
               idx_in = lchild[rmh_pkg::IDX_W-1:0];
            end
         end
         default: ;
      endcase
      // root kept in a register so the tops are free to read
      top_in = (we && wa == '0) ? wd : top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmh_pkg::H_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      lval_ff <= lval_in;
      top_ff  <= top_in;
   end

   // heap storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign stat.busy = (state_ff != rmh_pkg::H_IDLE);
   assign stat.top  = top_ff;
   assign stat.cnt  = cnt_ff;

endmodule

/* design/rmh_check.sv */
// Port-level checks for the running median block, bound to its top level.
module rmh_check (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic signed [rmh_pkg::SAMPLE_W-1:0]  req_sample,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [rmh_pkg::MED_W-1:0]     rsp_median_doubled,
   input logic                                 rsp_overflow,
   input logic [rmh_pkg::COUNT_W-1:0]          rsp_count
);

   // a held result word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_median_doubled) &&
      $stable(rsp_count) && $stable(rsp_overflow))
      else $error("result word changed while stalled");

   // one word in flight: stall straight after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   // a dropped sample only happens with both heaps full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_count == rmh_pkg::COUNT_W'(2 * rmh_pkg::HEAP_DEPTH))
      else $error("overflow without full heaps");

   // held count never exceeds the capacity and is never empty on a result
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != '0 &&
      rsp_count <= rmh_pkg::COUNT_W'(2 * rmh_pkg::HEAP_DEPTH))
      else $error("count out of range");

endmodule

bind running_median_two_heaps rmh_check u_rmh_check (.*);

/* sim/running_median_checker.sv */
// Checker for the running median block: predicts each word and compares results.
module running_median_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [rmh_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [rmh_pkg::MED_W-1:0]    rsp_median_doubled,
   input  logic                                rsp_overflow,
   input  logic [rmh_pkg::COUNT_W-1:0]         rsp_count,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  results_seen,
   output int                                  overflows_seen
);

   typedef struct {
      logic signed [rmh_pkg::MED_W-1:0] med2;
      logic                             ovf;
      logic [rmh_pkg::COUNT_W-1:0]      cnt;
   } median_word_type;

   // predicted heaps: sorted lists stand in for them, only the tops matter
   rmh_pkg::sample_type lower_set[$];   // descending, [0] is the max
   rmh_pkg::sample_type upper_set[$];   // ascending, [0] is the min
   median_word_type     medians_due[$];

   assign pending = medians_due.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %0d: %s got %0d expected %0d", results_seen, what, got, want);
      mismatches++;
   endtask

   // keep lower_set descending and upper_set ascending
   function automatic void put_lower(input rmh_pkg::sample_type v);
      int i;
      i = 0;
      while (i < lower_set.size() && lower_set[i] > v) i++;
      lower_set.insert(i, v);
   endfunction

   function automatic void put_upper(input rmh_pkg::sample_type v);
      int i;
      i = 0;
      while (i < upper_set.size() && upper_set[i] < v) i++;
      upper_set.insert(i, v);
   endfunction

   function automatic median_word_type insert_sample(input rmh_pkg::sample_type x);
      median_word_type     w;
      rmh_pkg::sample_type t;
      w.ovf = (lower_set.size() >= rmh_pkg::HEAP_DEPTH) &&
              (upper_set.size() >= rmh_pkg::HEAP_DEPTH);
      if (!w.ovf) begin
         if (lower_set.size() > upper_set.size()) begin
            if (x >= lower_set[0]) put_upper(x);
            else begin
               t = lower_set.pop_front();
               put_lower(x);
               put_upper(t);
            end
         end else begin
            if (upper_set.size() == 0 || x <= upper_set[0]) put_lower(x);
            else begin
               t = upper_set.pop_front();
               put_upper(x);
               put_lower(t);
            end
         end
      end
      if (lower_set.size() == 0) w.med2 = '0;
      else if (lower_set.size() > upper_set.size())
         w.med2 = {lower_set[0][rmh_pkg::SAMPLE_W-1], lower_set[0]} <<< 1;
      else
         w.med2 = {lower_set[0][rmh_pkg::SAMPLE_W-1], lower_set[0]}
                + {upper_set[0][rmh_pkg::SAMPLE_W-1], upper_set[0]};
      w.cnt = rmh_pkg::COUNT_W'(lower_set.size() + upper_set.size());
      return w;
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      median_word_type w;
      if (reset) begin
         lower_set.delete();
         upper_set.delete();
         medians_due.delete();
         mismatches     <= 0;
         results_seen   <= 0;
         overflows_seen <= 0;
      end else begin
         if (req_valid && !req_stall) medians_due.push_back(insert_sample(req_sample));
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (rsp_overflow) overflows_seen <= overflows_seen + 1;
            if (medians_due.size() == 0) report("unexpected word", 1, 0);
            else begin
               w = medians_due.pop_front();
               if (rsp_median_doubled !== w.med2)
                  report("median_doubled", rsp_median_doubled, w.med2);
               if (rsp_overflow !== w.ovf) report("overflow", rsp_overflow, w.ovf);
               if (rsp_count !== w.cnt) report("count", rsp_count, w.cnt);
            end
         end
      end
   end
endmodule

/* sim/running_median_two_heaps_test.sv */
// Testbench top: drives samples, stalls the result side and gives the verdict.
module running_median_two_heaps_test;

   localparam int CYCLE_LIMIT = 1200000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   rmh_pkg::sample_type              req_sample = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b1;
   logic signed [rmh_pkg::MED_W-1:0] rsp_median_doubled;
   logic                             rsp_overflow;
   logic [rmh_pkg::COUNT_W-1:0]      rsp_count;
   int                               mismatches, pending, results_seen, overflows_seen;
   int                               cycles = 0;
   int                               samples_sent = 0;
   bit                               hold_off = 1'b0;
   bit                               no_gaps = 1'b0;

   running_median_two_heaps dut (.*);

   running_median_checker checker_i (.*);

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stall per word, or a long hold-off
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 16);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // offer one word and wait for it to be taken
   task automatic send_sample(input rmh_pkg::sample_type s);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   function automatic rmh_pkg::sample_type random_sample();
      case ($urandom_range(0, 3))
         0: return rmh_pkg::sample_type'($urandom);
         1: return rmh_pkg::sample_type'($urandom_range(0, 40)) - 20;
         2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return rmh_pkg::sample_type'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, equal values, sign flips, alternating halves
      send_sample(32'sh7fff_ffff);
      send_sample(32'sh7fff_ffff);
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(0);
      send_sample(-1);
      send_sample(1);
      send_sample(0);
      send_sample(0);
      send_sample(32'sh5555_5555);
      send_sample(32'shaaaa_aaaa);
      send_sample(32'sh7fff_fffe);
      send_sample(32'sh8000_0001);
      send_sample(-1);
      send_sample(-1);

      // random words, with one long hold-off on the result side
      for (int i = 0; i < 584; i++) begin
         if (i == 200) hold_off = 1'b1;
         no_gaps = (i >= 350 && i < 420);
         send_sample(random_sample());
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d samples sent, %0d results checked, %0d with the heaps full",
               samples_sent, results_seen, overflows_seen);
      if (mismatches == 0 && pending == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
